// ===== rtl/ttx_rad_pkg.sv =====
`timescale 1ns / 1ps

package ttx_rad_pkg;

  localparam int COLUMNS_DEF = 40;
  localparam int ROWS_DEF    = 25;

  // configuration register indexes
  localparam logic [1:0] CFG_REVEAL = 2'd0;
  localparam logic [1:0] CFG_PAGE   = 2'd1;
  localparam logic [1:0] CFG_SUB    = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic {
    ST_DECODE,
    ST_EMIT
  } state_t;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    hex_char = (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h57 + {4'h0, v});
  endfunction

  // header cells of row 0: green alpha, page hex, dot, subpage hex, white alpha
  function automatic logic [7:0] header_byte(input logic [2:0] x, input logic [11:0] page,
                                             input logic [7:0] sub);
    logic [7:0] b;
    unique case (x)
      3'd0:    b = 8'h02;
      3'd1:    b = hex_char(page[11:8]);
      3'd2:    b = hex_char(page[7:4]);
      3'd3:    b = hex_char(page[3:0]);
      3'd4:    b = 8'h2e;
      3'd5:    b = hex_char(sub[7:4]);
      3'd6:    b = hex_char(sub[3:0]);
      default: b = 8'h07;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/teletext_row_attribute_decoder.sv =====
`timescale 1ns / 1ps

// Teletext level 1 row decoder: one code byte per input transfer, rows of COLUMNS cells.
// Each decoded cell is written to a single-port-per-side row buffer in the cycle its byte
// is taken. The byte that ends a row starts a readout pass that reads the row buffer
// one cell per cycle while the result side is not stalled and hands out COLUMNS result
// transfers; no byte is taken during the readout pass. The last cell of a row may still
// wait on the output while bytes of the next row are taken. Rows following a double
// height row are consumed without decoding and read back as blank copies. The row buffer
// has no reset and no clearing pass; every cell is written before it is read. Reset is
// synchronous, active low.
module teletext_row_attribute_decoder #(
  parameter int COLUMNS = ttx_rad_pkg::COLUMNS_DEF,
  parameter int ROWS    = ttx_rad_pkg::ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] code_byte
  input  logic        in_tuser,   // [0] page_start
  output logic        out_tvalid,
  input  logic        out_tready,
  // [4:0] row, [10:5] column, [18:11] glyph, [21:19] foreground, [24:22] background,
  // [25] mosaic, [26] separated, [27] flashing, [28] concealed, [29] double_height,
  // [30] plain_in_double_row, [31] zero
  output logic [31:0] out_tdata,
  output logic        out_tlast,  // last_in_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import ttx_rad_pkg::*;

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);
  localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

  // flags: [0] mosaic, [1] conceal, [2] flash, [3] separated, [4] double height
  typedef struct packed {
    logic [4:0] flags;
    logic [2:0] bg;
    logic [2:0] fg;
    logic [7:0] glyph;
  } cell_t;

  // configuration
  logic        reveal_r;
  logic [11:0] page_r;
  logic [7:0]  sub_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reveal_r <= 1'b0;
      page_r   <= 12'd256;
      sub_r    <= 8'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_REVEAL: reveal_r <= cfg_data[0];
        CFG_PAGE:   page_r   <= cfg_data;
        CFG_SUB:    sub_r    <= cfg_data[7:0];
        default:    ;
      endcase
    end
  end

  // decode state
  state_t        state_r, state_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [2:0]    fg_r, fg_nxt;
  logic [2:0]    bg_r, bg_nxt;
  logic [4:0]    flags_r, flags_nxt;
  logic          hold_r, hold_nxt;
  logic [7:0]    held_r, held_nxt;
  logic          has_dbl_r, has_dbl_nxt;
  logic          copy_r, copy_nxt;

  // readout
  logic [RW-1:0] em_row_r, em_row_nxt;
  logic [CW-1:0] em_addr_r, em_addr_nxt;
  logic          em_blank_r, em_blank_nxt;
  logic          em_dbl_r, em_dbl_nxt;
  logic          rd_en;

  // output register: memory read data plus the cell's position
  cell_t         rdata_r;
  logic          out_valid_r, out_valid_nxt;
  logic [RW-1:0] out_row_r;
  logic [CW-1:0] out_col_r;
  logic          out_blank_r;
  logic          out_dbl_r;
  logic          out_last_r;

  cell_t         row_mem [COLUMNS];
  cell_t         wcell;
  logic          mem_we;

  logic          in_xfer;
  logic [RW-1:0] s_row;
  logic [CW-1:0] s_col;
  logic          s_copy;
  logic          last_col;
  logic          ctrl;
  logic [7:0]    ch;

  assign in_tready = (state_r == ST_DECODE);
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    fg_nxt       = fg_r;
    bg_nxt       = bg_r;
    flags_nxt    = flags_r;
    hold_nxt     = hold_r;
    held_nxt     = held_r;
    has_dbl_nxt  = has_dbl_r;
    copy_nxt     = copy_r;
    em_row_nxt   = em_row_r;
    em_addr_nxt  = em_addr_r;
    em_blank_nxt = em_blank_r;
    em_dbl_nxt   = em_dbl_r;
    mem_we       = 1'b0;
    wcell        = '0;
    rd_en        = 1'b0;
    ctrl         = 1'b0;
    last_col     = 1'b0;
    ch           = in_tdata;
    s_row        = row_r;
    s_col        = col_r;
    s_copy       = copy_r;

    unique case (state_r)
      ST_DECODE: begin
        if (in_xfer) begin
          // page start: back to the top, drop partial row and pending copy row
          if (in_tuser) begin
            s_row       = '0;
            s_col       = '0;
            s_copy      = 1'b0;
            fg_nxt      = 3'd7;
            bg_nxt      = 3'd0;
            flags_nxt   = 5'd0;
            hold_nxt    = 1'b0;
            held_nxt    = CH_SPACE;
            has_dbl_nxt = 1'b0;
          end
          copy_nxt = s_copy;
          last_col = (s_col == LAST_COL);

          if (!s_copy) begin
            if (s_row == '0 && {1'b0, s_col} < (CW + 1)'(8))
              ch = header_byte(s_col[2:0], page_r, sub_r);
            if (ch < 8'h20) begin
              ctrl = 1'b1;
              unique case (ch[4:0])
                5'h00, 5'h01, 5'h02, 5'h03, 5'h04, 5'h05, 5'h06, 5'h07: begin
                  fg_nxt       = ch[2:0];
                  flags_nxt[0] = 1'b0;
                  flags_nxt[1] = 1'b0;
                end
                5'h10, 5'h11, 5'h12, 5'h13, 5'h14, 5'h15, 5'h16, 5'h17: begin
                  fg_nxt       = ch[2:0];
                  flags_nxt[0] = 1'b1;
                  flags_nxt[1] = 1'b0;
                end
                5'h08: flags_nxt[2] = 1'b1;
                5'h09: flags_nxt[2] = 1'b0;
                5'h0c: flags_nxt[4] = 1'b0;
                5'h0d: begin
                  // ignored on the last two rows
                  if ((RW + 2)'(s_row) + (RW + 2)'(2) < (RW + 2)'(ROWS)) begin
                    flags_nxt[4] = 1'b1;
                    has_dbl_nxt  = 1'b1;
                  end
                end
                5'h18: flags_nxt[1] = 1'b1;
                5'h19: flags_nxt[3] = 1'b0;
                5'h1a: flags_nxt[3] = 1'b1;
                5'h1c: bg_nxt = 3'd0;
                5'h1d: bg_nxt = fg_nxt;
                5'h1e: hold_nxt = 1'b1;
                5'h1f: hold_nxt = 1'b0;
                5'h0e, 5'h0f, 5'h1b: ctrl = 1'b0;
                default: ;
              endcase
              ch = CH_SPACE;
              if (ctrl && hold_nxt && flags_nxt[0])
                ch = held_nxt;
            end
            if (flags_nxt[0] && (ch & 8'ha0) == 8'h20) begin
              held_nxt = ch;
              ch       = ch[6] ? ch + 8'd32 : ch - 8'd32;
            end
            if (flags_nxt[1] && !reveal_r)
              ch = CH_SPACE;
            // capture the cell before the row end restarts the attributes
            wcell  = {flags_nxt, bg_nxt, fg_nxt, ch};
            mem_we = 1'b1;
          end

          if (last_col) begin
            // row end: start the readout, move to the next row
            state_nxt    = ST_EMIT;
            em_row_nxt   = s_row;
            em_addr_nxt  = '0;
            em_blank_nxt = s_copy;
            em_dbl_nxt   = s_copy ? 1'b1 : has_dbl_nxt;
            copy_nxt     = s_copy ? 1'b0 : has_dbl_nxt;
            row_nxt      = (s_row == LAST_ROW) ? '0 : s_row + 1'b1;
            col_nxt      = '0;
            fg_nxt       = 3'd7;
            bg_nxt       = 3'd0;
            flags_nxt    = 5'd0;
            hold_nxt     = 1'b0;
            held_nxt     = CH_SPACE;
            has_dbl_nxt  = 1'b0;
          end else begin
            row_nxt = s_row;
            col_nxt = s_col + 1'b1;
          end
        end
      end
      ST_EMIT: begin
        // no writes here, so reads never meet a write to the same cell
        rd_en = !out_valid_r || out_tready;
        if (rd_en) begin
          em_addr_nxt = em_addr_r + 1'b1;
          if (em_addr_r == LAST_COL)
            state_nxt = ST_DECODE;
        end
      end
      default: state_nxt = ST_DECODE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rd_en)
      out_valid_nxt = 1'b1;
    else if (out_tready)
      out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_DECODE;
      row_r       <= '0;
      col_r       <= '0;
      fg_r        <= 3'd7;
      bg_r        <= 3'd0;
      flags_r     <= 5'd0;
      hold_r      <= 1'b0;
      held_r      <= CH_SPACE;
      has_dbl_r   <= 1'b0;
      copy_r      <= 1'b0;
      em_addr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      fg_r        <= fg_nxt;
      bg_r        <= bg_nxt;
      flags_r     <= flags_nxt;
      hold_r      <= hold_nxt;
      held_r      <= held_nxt;
      has_dbl_r   <= has_dbl_nxt;
      copy_r      <= copy_nxt;
      em_addr_r   <= em_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    em_row_r   <= em_row_nxt;
    em_blank_r <= em_blank_nxt;
    em_dbl_r   <= em_dbl_nxt;
    if (rd_en) begin
      out_row_r   <= em_row_r;
      out_col_r   <= em_addr_r;
      out_blank_r <= em_blank_r;
      out_dbl_r   <= em_dbl_r;
      out_last_r  <= (em_addr_r == LAST_COL);
    end
  end

  // row buffer
  always_ff @(posedge clk) begin
    if (mem_we)
      row_mem[s_col] <= wcell;
    if (rd_en)
      rdata_r <= row_mem[em_addr_r];
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0,
                       out_dbl_r & ~rdata_r.flags[4],
                       rdata_r.flags[4],
                       rdata_r.flags[1],
                       rdata_r.flags[2],
                       rdata_r.flags[3],
                       rdata_r.flags[0],
                       rdata_r.bg,
                       rdata_r.fg,
                       out_blank_r ? CH_SPACE : rdata_r.glyph,
                       6'(out_col_r),
                       5'(out_row_r)};

endmodule

// ===== rtl/ttx_rad_checker.sv =====
`timescale 1ns / 1ps

module ttx_rad_checker #(
  parameter int COLUMNS = ttx_rad_pkg::COLUMNS_DEF,
  parameter int ROWS    = ttx_rad_pkg::ROWS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // the last cell of a row sits in the last column
  a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[10:5] == 6'(COLUMNS - 1))
    else $error("row end not at last column");

  // cells of one row follow back to back
  a_row_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a row readout");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> {1'b0, out_tdata[4:0]} < 6'(ROWS))
    else $error("row out of range");

endmodule

bind teletext_row_attribute_decoder ttx_rad_checker #(
  .COLUMNS(COLUMNS),
  .ROWS(ROWS)
) u_ttx_rad_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);

// ===== verif/teletext_row_attribute_decoder_tb.sv =====
`timescale 1ns / 1ps

module teletext_row_attribute_decoder_tb;
  import ttx_rad_pkg::*;

  localparam int COLS = COLUMNS_DEF;
  localparam int ROWS = ROWS_DEF;

  // spacing attribute codes
  localparam logic [7:0] C_ALPHA_GREEN = 8'h02;
  localparam logic [7:0] C_ALPHA_WHITE = 8'h07;
  localparam logic [7:0] C_FLASH       = 8'h08;
  localparam logic [7:0] C_STEADY      = 8'h09;
  localparam logic [7:0] C_NORMAL      = 8'h0c;
  localparam logic [7:0] C_DOUBLE      = 8'h0d;
  localparam logic [7:0] C_SO          = 8'h0e;
  localparam logic [7:0] C_SI          = 8'h0f;
  localparam logic [7:0] C_CONCEAL     = 8'h18;
  localparam logic [7:0] C_CONTIG      = 8'h19;
  localparam logic [7:0] C_SEP         = 8'h1a;
  localparam logic [7:0] C_ESC         = 8'h1b;
  localparam logic [7:0] C_BLACK_BG    = 8'h1c;
  localparam logic [7:0] C_NEW_BG      = 8'h1d;
  localparam logic [7:0] C_HOLD        = 8'h1e;
  localparam logic [7:0] C_RELEASE     = 8'h1f;
  localparam logic [7:0] C_DOT         = 8'h2e;

  // bit positions in the attribute word
  localparam int A_MOSAIC  = 0;
  localparam int A_CONCEAL = 1;
  localparam int A_FLASH   = 2;
  localparam int A_SEP     = 3;
  localparam int A_DOUBLE  = 4;

  localparam int LONG_HOLD_CYCLES = 400;

  typedef struct {
    logic [7:0] glyph;
    logic [2:0] fg;
    logic [2:0] bg;
    logic [4:0] attr;
    logic       plain;
  } line_cell_t;

  typedef struct {
    logic [4:0] row;
    logic [5:0] column;
    logic [7:0] glyph;
    logic [2:0] fg;
    logic [2:0] bg;
    logic       mosaic;
    logic       separated;
    logic       flashing;
    logic       concealed;
    logic       double_height;
    logic       plain;
    logic       last;
  } cell_result_t;

  typedef struct {
    logic [7:0] code;
    logic       start;
    int         run;
    logic [7:0] glyph;
    logic       pinned;
  } page_run_t;

  typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_PATTERN} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] code_byte
  logic        in_tuser = 1'b0; // [0] page_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [4:0] row, [10:5] column, [18:11] glyph, [21:19] foreground, [24:22] background,
  // [25] mosaic, [26] separated, [27] flashing, [28] concealed, [29] double_height,
  // [30] plain_in_double_row, [31] zero
  logic [31:0] out_tdata;
  logic        out_tlast;       // last_in_run
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  teletext_row_attribute_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // decoder shadow state
  logic        pr_reveal;
  logic [11:0] pr_page;
  logic [7:0]  pr_sub;
  logic [4:0]  pr_row;
  logic [5:0]  pr_col;
  logic [2:0]  pr_fg;
  logic [2:0]  pr_bg;
  logic [4:0]  pr_attr;
  logic        pr_hold;
  logic [7:0]  pr_held;
  logic        pr_row_double;
  logic        pr_copy_due;
  line_cell_t  pr_line [COLS];

  cell_result_t expected_cells [$];

  int fail_count = 0;
  int reported = 0;
  int burst_left = 0;

  logic        long_hold_req = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned mode_left = 0;
  int unsigned rx_tick = 0;
  rx_mode_t    rx_mode = RX_OPEN;

  page_run_t directed [27] = '{
    '{8'h5a,      1'b1, 1,   CH_SPACE, 1'b1},  // header green alpha
    '{8'h00,      1'b0, 1,   8'h31,    1'b1},  // hundreds digit of page 0x100
    '{8'hff,      1'b0, 6,   8'h00,    1'b0},
    '{C_CONCEAL,  1'b0, 1,   CH_SPACE, 1'b1},
    '{8'h41,      1'b0, 1,   CH_SPACE, 1'b1},  // concealed, reveal off
    '{8'h17,      1'b0, 1,   8'h00,    1'b0},  // mosaic white
    '{8'h3f,      1'b0, 1,   8'h1f,    1'b1},
    '{C_HOLD,     1'b0, 1,   8'h00,    1'b0},
    '{8'h7f,      1'b0, 1,   8'h9f,    1'b1},
    '{C_SEP,      1'b0, 1,   8'h00,    1'b0},
    '{C_SO,       1'b0, 1,   8'h00,    1'b0},
    '{C_NEW_BG,   1'b0, 1,   8'h00,    1'b0},
    '{C_FLASH,    1'b0, 1,   8'h00,    1'b0},
    '{8'h80,      1'b0, 1,   8'h80,    1'b1},
    '{8'hff,      1'b0, 1,   8'hff,    1'b1},
    '{C_DOUBLE,   1'b0, 1,   8'h00,    1'b0},
    '{C_NORMAL,   1'b0, 1,   8'h00,    1'b0},
    '{C_BLACK_BG, 1'b0, 1,   8'h00,    1'b0},
    '{C_STEADY,   1'b0, 1,   8'h00,    1'b0},
    '{C_RELEASE,  1'b0, 1,   8'h00,    1'b0},
    '{C_CONTIG,   1'b0, 1,   8'h00,    1'b0},
    '{C_SI,       1'b0, 1,   8'h00,    1'b0},
    '{C_ESC,      1'b0, 1,   8'h00,    1'b0},
    '{8'h05,      1'b0, 1,   8'h00,    1'b0},
    '{8'h61,      1'b0, 11,  8'h00,    1'b0},  // rest of row 0
    '{8'h55,      1'b0, 10,  8'h00,    1'b0},  // part of the copy row under the double row
    '{8'h41,      1'b1, 40,  8'h00,    1'b0}   // page start drops the pending copy row
  };

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h61 + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] header_code(input logic [2:0] x);
    case (x)
      3'd0:    return C_ALPHA_GREEN;
      3'd1:    return nibble_char(pr_page[11:8]);
      3'd2:    return nibble_char(pr_page[7:4]);
      3'd3:    return nibble_char(pr_page[3:0]);
      3'd4:    return C_DOT;
      3'd5:    return nibble_char(pr_sub[7:4]);
      3'd6:    return nibble_char(pr_sub[3:0]);
      default: return C_ALPHA_WHITE;
    endcase
  endfunction

  task automatic restart_row();
    pr_fg = 3'd7;
    pr_bg = 3'd0;
    pr_attr = '0;
    pr_hold = 1'b0;
    pr_held = CH_SPACE;
    pr_row_double = 1'b0;
    pr_col = '0;
  endtask

  task automatic advance_row();
    if (pr_row == ROWS - 1)
      pr_row = '0;
    else
      pr_row = pr_row + 5'd1;
    restart_row();
  endtask

  task automatic queue_row_cells(input logic blank);
    cell_result_t r;
    for (int x = 0; x < COLS; x++) begin
      r.row = pr_row;
      r.column = 6'(x);
      r.glyph = blank ? CH_SPACE : pr_line[x].glyph;
      r.fg = pr_line[x].fg;
      r.bg = pr_line[x].bg;
      r.mosaic = pr_line[x].attr[A_MOSAIC];
      r.separated = pr_line[x].attr[A_SEP];
      r.flashing = pr_line[x].attr[A_FLASH];
      r.concealed = pr_line[x].attr[A_CONCEAL];
      r.double_height = pr_line[x].attr[A_DOUBLE];
      r.plain = pr_line[x].plain;
      r.last = (x == COLS - 1);
      expected_cells.push_back(r);
    end
  endtask

  task automatic decode_cell(input logic [7:0] code);
    logic [7:0] ch;
    logic       ctrl;
    ch = code;
    ctrl = 1'b0;
    if (pr_row == 0 && pr_col < 8)
      ch = header_code(pr_col[2:0]);
    if (ch < 8'h20) begin
      ctrl = 1'b1;
      if (ch <= C_ALPHA_WHITE) begin
        pr_fg = ch[2:0];
        pr_attr[A_MOSAIC] = 1'b0;
        pr_attr[A_CONCEAL] = 1'b0;
      end else if (ch >= 8'h10 && ch <= 8'h17) begin
        pr_fg = ch[2:0];
        pr_attr[A_MOSAIC] = 1'b1;
        pr_attr[A_CONCEAL] = 1'b0;
      end else begin
        case (ch)
          C_FLASH:    pr_attr[A_FLASH] = 1'b1;
          C_STEADY:   pr_attr[A_FLASH] = 1'b0;
          C_NORMAL:   pr_attr[A_DOUBLE] = 1'b0;
          C_DOUBLE: begin
            if (int'(pr_row) + 2 < ROWS) begin
              pr_attr[A_DOUBLE] = 1'b1;
              pr_row_double = 1'b1;
            end
          end
          C_CONCEAL:  pr_attr[A_CONCEAL] = 1'b1;
          C_CONTIG:   pr_attr[A_SEP] = 1'b0;
          C_SEP:      pr_attr[A_SEP] = 1'b1;
          C_BLACK_BG: pr_bg = 3'd0;
          C_NEW_BG:   pr_bg = pr_fg;
          C_HOLD:     pr_hold = 1'b1;
          C_RELEASE:  pr_hold = 1'b0;
          C_SO, C_SI, C_ESC: ctrl = 1'b0;
          default: ;
        endcase
      end
      ch = CH_SPACE;
      if (ctrl && pr_hold && pr_attr[A_MOSAIC])
        ch = pr_held;
    end
    if (pr_attr[A_MOSAIC] && (ch & 8'ha0) == 8'h20) begin
      pr_held = ch;
      ch = ch[6] ? ch + 8'd32 : ch - 8'd32;
    end
    if (pr_attr[A_CONCEAL] && !pr_reveal)
      ch = CH_SPACE;
    pr_line[pr_col].glyph = ch;
    pr_line[pr_col].fg = pr_fg;
    pr_line[pr_col].bg = pr_bg;
    pr_line[pr_col].attr = pr_attr;
    pr_line[pr_col].plain = 1'b0;
  endtask

  // written_col is -1 when the byte falls in a copy row and is not decoded
  task automatic decode_page_byte(input logic [7:0] code, input logic start,
                                  output int written_col);
    logic dbl;
    written_col = -1;
    if (start) begin
      pr_row = '0;
      pr_copy_due = 1'b0;
      restart_row();
    end
    if (pr_copy_due) begin
      if (pr_col >= COLS - 1) begin
        queue_row_cells(1'b1);
        pr_copy_due = 1'b0;
        advance_row();
      end else begin
        pr_col = pr_col + 6'd1;
      end
    end else begin
      written_col = int'(pr_col);
      decode_cell(code);
      if (pr_col >= COLS - 1) begin
        dbl = pr_row_double;
        if (dbl)
          for (int x = 0; x < COLS; x++)
            if (!pr_line[x].attr[A_DOUBLE])
              pr_line[x].plain = 1'b1;
        queue_row_cells(1'b0);
        advance_row();
        if (dbl)
          pr_copy_due = 1'b1;
      end else begin
        pr_col = pr_col + 6'd1;
      end
    end
  endtask

  function automatic logic [7:0] random_code();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 4)
      return 8'($urandom_range(0, 31));
    else if (k < 8)
      return 8'($urandom_range(32, 127));
    return 8'($urandom_range(128, 255));
  endfunction

  // Starts and ends just after a falling edge; paces the sender in bursts.
  task automatic send_code(input logic [7:0] code, input logic start, output int written_col);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= code;
    in_tuser <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_page_byte(code, start, written_col);
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 48);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_register(input logic [1:0] idx, input logic [11:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_REVEAL: pr_reveal = value[0];
      CFG_PAGE:   pr_page = value;
      CFG_SUB:    pr_sub = value[7:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic configure(input logic rev, input logic [11:0] page, input logic [7:0] sub);
    write_register(CFG_REVEAL, {11'd0, rev});
    write_register(CFG_PAGE, page);
    write_register(CFG_SUB, {4'd0, sub});
    cfg_valid <= 1'b0;
  endtask

  // hold off until every row has come out, then let the block settle
  task automatic wait_until_idle();
    in_tvalid <= 1'b0;
    while (expected_cells.size() != 0) @(negedge clk);
    repeat (2 * COLS) @(negedge clk);
  endtask

  task automatic check_cell(input logic [31:0] d, input logic last);
    cell_result_t a;
    cell_result_t e;
    a.row = d[4:0];
    a.column = d[10:5];
    a.glyph = d[18:11];
    a.fg = d[21:19];
    a.bg = d[24:22];
    a.mosaic = d[25];
    a.separated = d[26];
    a.flashing = d[27];
    a.concealed = d[28];
    a.double_height = d[29];
    a.plain = d[30];
    a.last = last;
    if (expected_cells.size() == 0) begin
      fail_count++;
      if (reported < 10) begin
        $display("unexpected cell row %0d col %0d glyph %h", a.row, a.column, a.glyph);
        reported++;
      end
      return;
    end
    e = expected_cells.pop_front();
    if (a.row !== e.row || a.column !== e.column || a.glyph !== e.glyph ||
        a.fg !== e.fg || a.bg !== e.bg || a.mosaic !== e.mosaic ||
        a.separated !== e.separated || a.flashing !== e.flashing ||
        a.concealed !== e.concealed || a.double_height !== e.double_height ||
        a.plain !== e.plain || a.last !== e.last) begin
      fail_count++;
      if (reported < 10) begin
        $display("cell mismatch exp r%0d c%0d g%h fg%0d bg%0d msfcdp%b%b%b%b%b%b l%b",
                 e.row, e.column, e.glyph, e.fg, e.bg, e.mosaic, e.separated,
                 e.flashing, e.concealed, e.double_height, e.plain, e.last);
        $display("              got r%0d c%0d g%h fg%0d bg%0d msfcdp%b%b%b%b%b%b l%b",
                 a.row, a.column, a.glyph, a.fg, a.bg, a.mosaic, a.separated,
                 a.flashing, a.concealed, a.double_height, a.plain, a.last);
        reported++;
      end
    end
  endtask

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready)
      check_cell(out_tdata, out_tlast);

  // result side: changing stall patterns, plus one long hold on request
  always @(negedge clk) begin
    rx_tick++;
    if (hold_cycles != 0) begin
      hold_cycles--;
      out_tready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_cycles = LONG_HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 200);
      end
      mode_left--;
      case (rx_mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_HALF:   out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
        default:   out_tready <= (rx_tick % 7) < 4;
      endcase
    end
  end

  initial begin
    #2_000_000;
    $display("teletext_row_attribute_decoder test failed");
    $finish;
  end

  initial begin
    int          col;
    int          decoded_items;
    logic        first;
    logic        rev;
    logic [11:0] page;
    logic [7:0]  sub;

    pr_reveal = 1'b0;
    pr_page = 12'd256;
    pr_sub = 8'd0;
    pr_row = '0;
    pr_copy_due = 1'b0;
    restart_row();
    for (int x = 0; x < COLS; x++)
      pr_line[x] = '{8'h00, 3'd0, 3'd0, 5'd0, 1'b0};

    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    configure(1'b0, 12'd256, 8'd0);

    // directed runs; a pinned glyph replaces the prediction for the first cell of the run
    foreach (directed[i])
      for (int k = 0; k < directed[i].run; k++) begin
        send_code(directed[i].code, directed[i].start && k == 0, col);
        if (k == 0 && directed[i].pinned && col >= 0)
          pr_line[col].glyph = directed[i].glyph;
      end

    for (int ph = 0; ph < 4; ph++) begin
      wait_until_idle();
      case (ph)
        0: begin rev = 1'b1; page = 12'h8ff; sub = 8'hff; end
        1: begin rev = 1'b0; page = 12'($urandom_range(256, 2303)); sub = 8'($urandom); end
        2: begin rev = 1'b1; page = 12'h100; sub = 8'($urandom); end
        default: begin rev = 1'b0; page = 12'($urandom_range(256, 2303)); sub = 8'h00; end
      endcase
      configure(rev, page, sub);
      if (ph == 1)
        long_hold_req = 1'b1;
      decoded_items = 0;
      first = 1'b1;
      // no stray page start under the long hold, so a row always ends and fills the block
      while (decoded_items < 48) begin
        send_code(random_code(), first || (ph != 1 && $urandom_range(0, 99) == 0), col);
        first = 1'b0;
        if (col >= 0)
          decoded_items++;
      end
    end

    in_tvalid <= 1'b0;
    for (int w = 0; w < 100000 && expected_cells.size() != 0; w++) @(posedge clk);
    repeat (2 * COLS) @(posedge clk);
    fail_count += expected_cells.size();

    if (fail_count == 0)
      $display("teletext_row_attribute_decoder test passed");
    else
      $display("teletext_row_attribute_decoder test failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ttx_rad_pkg.sv
rtl/teletext_row_attribute_decoder.sv
rtl/ttx_rad_checker.sv
verif/teletext_row_attribute_decoder_tb.sv
